>>> hw/rtl/sha1_pkg.sv
package sha1_pkg;

    localparam logic [31:0] H0_INIT = 32'h67452301;
    localparam logic [31:0] H1_INIT = 32'hEFCDAB89;
    localparam logic [31:0] H2_INIT = 32'h98BADCFE;
    localparam logic [31:0] H3_INIT = 32'h10325476;
    localparam logic [31:0] H4_INIT = 32'hC3D2E1F0;
    localparam logic [31:0] K0 = 32'h5A827999;
    localparam logic [31:0] K1 = 32'h6ED9EBA1;
    localparam logic [31:0] K2 = 32'h8F1BBCDC;
    localparam logic [31:0] K3 = 32'hCA62C1D6;
    localparam logic [7:0]  PAD_BYTE = 8'h80;
    localparam logic [6:0]  LAST_ROUND = 7'd79;
    localparam logic [2:0]  LAST_IDX = 3'd4;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_ROUND,
        ST_PAD,
        ST_OUT
    } t_state;

    // controller -> datapath
    typedef struct packed {
        logic put_byte;   // store in-byte, count it
        logic pad_start;  // place 0x80 at fill position
        logic pad_zero;   // place zero at fill position
        logic put_len;    // write length words 14,15
        logic clr_words;  // zero whole block (second padding block)
        logic blk_start;  // load working vars from chain
        logic round;      // run one round
        logic blk_end;    // add working vars into chain
        logic reinit;     // back to initial values
        logic shift_out;  // advance digest output
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic       block_full;  // next byte fills the block
        logic [5:0] fill;
        logic       round_done;
    } t_stat;

    function automatic logic [31:0] rotl(input logic [31:0] v, input int s);
        rotl = (v << s) | (v >> (32 - s));
    endfunction

endpackage

>>> hw/rtl/sha1_datapath.sv
module sha1_datapath
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  t_cmd        i_cmd,
    input  logic [7:0]  i_data_byte,
    output t_stat       o_stat,
    output logic [31:0] o_digest_word
);

    logic [31:0] r_h [5];
    logic [31:0] r_v [5];
    logic [31:0] r_w [16];
    logic [5:0]  r_fill;
    logic [60:0] r_msg;
    logic [6:0]  r_t;

    logic [3:0]  s_widx;
    logic [4:0]  s_sh;
    logic [7:0]  s_byte;
    logic        s_place;
    logic [31:0] s_wnew;
    logic [31:0] s_wt;
    logic [31:0] s_f;
    logic [31:0] s_k;
    logic [31:0] s_tmp;
    logic [63:0] s_bits;

    assign s_widx = r_fill[5:2];
    assign s_sh   = 5'(24 - 8 * int'(r_fill[1:0]));
    assign s_byte = i_cmd.pad_start ? PAD_BYTE : (i_cmd.put_byte ? i_data_byte : 8'd0);
    assign s_place = i_cmd.put_byte | i_cmd.pad_start | i_cmd.pad_zero;
    assign s_bits = {r_msg, 3'b000};

    // schedule expansion on the 16-word window, indexed by round
    assign s_wnew = rotl(r_w[4'(r_t - 7'd3)] ^ r_w[4'(r_t - 7'd8)]
                       ^ r_w[4'(r_t - 7'd14)] ^ r_w[r_t[3:0]], 1);
    assign s_wt = (r_t < 7'd16) ? r_w[r_t[3:0]] : s_wnew;

    // round function
    always_comb begin
        if (r_t < 7'd20) begin
            s_f = (r_v[1] & r_v[2]) | (~r_v[1] & r_v[3]);
            s_k = K0;
        end else if (r_t < 7'd40) begin
            s_f = r_v[1] ^ r_v[2] ^ r_v[3];
            s_k = K1;
        end else if (r_t < 7'd60) begin
            s_f = (r_v[1] & r_v[2]) | (r_v[1] & r_v[3]) | (r_v[2] & r_v[3]);
            s_k = K2;
        end else begin
            s_f = r_v[1] ^ r_v[2] ^ r_v[3];
            s_k = K3;
        end
    end
    assign s_tmp = rotl(r_v[0], 5) + s_f + r_v[4] + s_wt + s_k;

    // block word buffer
    always_ff @(posedge i_clk) begin
        if (i_cmd.clr_words) begin
            for (int i = 0; i < 16; i++) r_w[i] <= '0;
        end else if (s_place) begin
            if (r_fill[1:0] == 2'd0) r_w[s_widx] <= {s_byte, 24'd0};
            else r_w[s_widx] <= r_w[s_widx] | (32'(s_byte) << s_sh);
        end else if (i_cmd.put_len) begin
            r_w[14] <= s_bits[63:32];
            r_w[15] <= s_bits[31:0];
        end else if (i_cmd.round && r_t >= 7'd16) begin
            r_w[r_t[3:0]] <= s_wnew;
        end
    end

    // fill, length and round counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_fill <= '0;
            r_msg  <= '0;
        end else begin
            if (s_place) r_fill <= r_fill + 6'd1;
            if (i_cmd.put_byte) r_msg <= r_msg + 61'd1;
        end
        if (!i_rst_n || i_cmd.blk_start) r_t <= '0;
        else if (i_cmd.round) r_t <= r_t + 7'd1;
    end

    // chain and working variables; chain also shifts out as digest
    always_ff @(posedge i_clk) begin
        if (!i_rst_n || i_cmd.reinit) begin
            r_h[0] <= H0_INIT; r_h[1] <= H1_INIT; r_h[2] <= H2_INIT;
            r_h[3] <= H3_INIT; r_h[4] <= H4_INIT;
        end else if (i_cmd.blk_end) begin
            for (int i = 0; i < 5; i++) r_h[i] <= r_h[i] + r_v[i];
        end else if (i_cmd.shift_out) begin
            for (int i = 0; i < 4; i++) r_h[i] <= r_h[i + 1];
            r_h[4] <= r_h[0];
        end
        if (!i_rst_n) begin
            for (int i = 0; i < 5; i++) r_v[i] <= '0;
        end else if (i_cmd.blk_start) begin
            for (int i = 0; i < 5; i++) r_v[i] <= r_h[i];
        end else if (i_cmd.round) begin
            r_v[0] <= s_tmp;
            r_v[1] <= r_v[0];
            r_v[2] <= rotl(r_v[1], 30);
            r_v[3] <= r_v[2];
            r_v[4] <= r_v[3];
        end
    end

    // done once all 80 rounds have been applied
    assign o_stat.block_full = (r_fill == 6'd63);
    assign o_stat.fill       = r_fill;
    assign o_stat.round_done = (r_t == LAST_ROUND + 7'd1);
    assign o_digest_word     = r_h[0];

endmodule

>>> hw/rtl/sha1_ctrl.sv
module sha1_ctrl
    import sha1_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic       i_byte_valid,
    input  logic       i_last,
    input  logic       i_stall,
    input  t_stat      i_stat,
    output logic       o_stall,
    output logic       o_valid,
    output logic [2:0] o_word_index,
    output logic       o_last_word,
    output t_cmd       o_cmd
);

    t_state     r_state, n_state;
    logic       r_fin, n_fin;      // finish pending after current block
    logic       r_two, n_two;      // second padding block follows
    logic [2:0] r_idx, n_idx;
    logic       s_acc;

    assign s_acc = i_valid && (r_state == ST_IDLE);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_fin   <= 1'b0;
            r_two   <= 1'b0;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_fin   <= n_fin;
            r_two   <= n_two;
            r_idx   <= n_idx;
        end
    end

    // next state and commands
    always_comb begin
        n_state = r_state;
        n_fin   = r_fin;
        n_two   = r_two;
        n_idx   = r_idx;
        o_cmd   = '0;
        case (r_state)
            ST_IDLE: begin
                if (s_acc) begin
                    o_cmd.put_byte = i_byte_valid;
                    n_fin = i_last;
                    if (i_byte_valid && i_stat.block_full) begin
                        o_cmd.blk_start = 1'b1;
                        n_state = ST_ROUND;
                    end else if (i_last) begin
                        n_state = ST_PAD;
                    end
                end
            end
            ST_PAD: begin
                // one padding byte a cycle, then length or block close
                if (r_two) begin
                    o_cmd.clr_words = 1'b1;
                    n_two = 1'b0;
                end else if (i_stat.fill == 6'd56 && !o_cmd.clr_words
                             && r_fin && !r_two && r_idx == 3'd7) begin
                    o_cmd.put_len = 1'b1;
                end
                if (r_idx == 3'd7) begin
                    // zero fill has reached length area; final block marked by index 5
                    if (i_stat.fill == 6'd56) begin
                        o_cmd.put_len = 1'b1;
                        o_cmd.blk_start = 1'b1;
                        n_fin = 1'b0;
                        n_idx = 3'd5;
                        n_state = ST_ROUND;
                    end else begin
                        o_cmd.pad_zero = 1'b1;
                    end
                end else if (r_idx == 3'd6) begin
                    // second block wanted, fill to 64 and run
                    if (i_stat.fill == 6'd63) begin
                        o_cmd.pad_zero = 1'b1;
                        o_cmd.blk_start = 1'b1;
                        n_two = 1'b1;
                        n_state = ST_ROUND;
                    end else begin
                        o_cmd.pad_zero = 1'b1;
                    end
                end else begin
                    o_cmd.pad_start = 1'b1;
                    if (i_stat.fill >= 6'd56) begin
                        if (i_stat.fill == 6'd63) begin
                            o_cmd.blk_start = 1'b1;
                            n_two = 1'b1;
                            n_state = ST_ROUND;
                        end else begin
                            n_idx = 3'd6;
                        end
                    end else begin
                        n_idx = 3'd7;
                    end
                end
            end
            ST_ROUND: begin
                o_cmd.round = 1'b1;
                if (i_stat.round_done) begin
                    n_state = ST_IDLE;
                    n_idx = '0;
                    if (r_fin && !r_two) begin
                        n_state = ST_PAD;
                    end else if (r_two) begin
                        n_state = ST_PAD;
                        n_idx = 3'd7;
                    end else if (!r_fin) begin
                        n_state = r_idx == 3'd5 ? ST_OUT : ST_IDLE;
                    end
                end
            end
            ST_OUT: begin
                if (!i_stall) begin
                    o_cmd.shift_out = 1'b1;
                    n_idx = r_idx + 3'd1;
                    if (r_idx == LAST_IDX) begin
                        o_cmd.reinit = 1'b1;
                        n_idx = '0;
                        n_state = ST_IDLE;
                    end
                end
            end
            default: n_state = ST_IDLE;
        endcase
        // block end folds into the cycle after the final round
        if (r_state == ST_ROUND && i_stat.round_done) begin
            o_cmd.round = 1'b0;
            o_cmd.blk_end = 1'b1;
        end
    end

    assign o_stall      = (r_state != ST_IDLE);
    assign o_valid      = (r_state == ST_OUT);
    assign o_word_index = r_idx;
    assign o_last_word  = (r_idx == LAST_IDX);

`ifndef ASSERT_OFF
    a_out_idx: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_OUT) |-> (r_idx <= LAST_IDX))
        else $error("digest index out of range");
    a_no_acc_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_ROUND) |-> !s_acc)
        else $error("word accepted during rounds");
    a_end_once: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.blk_end |=> !o_cmd.blk_end)
        else $error("chain update repeated");
`endif

endmodule

>>> hw/rtl/sha1_hash_engine_unit.sv
// A byte that completes a block holds off input during its 80 rounds and the chain update.
// After the last word: padding bytes and length fill one or two blocks, then 5 digest words.
// One byte a cycle within a block; input is held off (o_stall) after each 64-byte block.
// Rate is set by the single shared round unit, one SHA-1 round a cycle.
// Reset (synchronous, active low) loads initial chain values and clears counters.
module sha1_hash_engine_unit
    import sha1_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_valid,
    output logic        o_stall,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_last,
    output logic        o_valid,
    input  logic        i_stall,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    t_cmd  s_cmd;
    t_stat s_stat;

    sha1_ctrl u_ctrl (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .i_byte_valid (i_byte_valid),
        .i_last       (i_last),
        .i_stall      (i_stall),
        .i_stat       (s_stat),
        .o_stall      (o_stall),
        .o_valid      (o_valid),
        .o_word_index (o_word_index),
        .o_last_word  (o_last_word),
        .o_cmd        (s_cmd)
    );

    sha1_datapath u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (s_cmd),
        .i_data_byte   (i_data_byte),
        .o_stat        (s_stat),
        .o_digest_word (o_digest_word)
    );

endmodule
